@@ sv/tbvm_pkg.sv @@
// Shared types and constants for the bytecode VM engine.
package tbvm_pkg;

  localparam logic [7:0] OP_ADD  = 8'h01;
  localparam logic [7:0] OP_SUB  = 8'h02;
  localparam logic [7:0] OP_LD   = 8'h03;
  localparam logic [7:0] OP_RET  = 8'hFF;
  localparam logic [7:0] SEL_IMM = 8'hFF;

  localparam logic [1:0] STAT_RET = 2'd0;
  localparam logic [1:0] STAT_END = 2'd1;
  localparam logic [1:0] STAT_BAD = 2'd2;

  typedef struct packed {
    logic [7:0]  op;
    logic [3:0]  dst;
    logic [7:0]  src;
    logic [31:0] imm;
  } insn_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SETUP,
    S_RUN,
    S_DONE
  } vm_state_t;

endpackage

@@ sv/tiny_bytecode_vm_engine.sv @@
// Bytecode VM engine: program store plus pipelined interpreter on one shared ALU.
// Load request: taken in S_IDLE, next request accepted the following cycle.
// Execute request: the run ends when a RET reaches the ALU stage or when it falls off the end;
// instructions flow through fetch / register-read / ALU, one per cycle.
// Invalid slot: result with status BAD, no program run. No item accepted while a run is in progress.
// Synchronous active-low reset empties the program store; no clearing pass is needed.
module tiny_bytecode_vm_engine import tbvm_pkg::*; #(
  parameter int NUM_PROGRAMS    = 64,
  parameter int MAX_PROGRAM_LEN = 256,
  parameter int NUM_REGS        = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_kind,
  input  logic [7:0]         in_opcode,
  input  logic [3:0]         in_dest_reg,
  input  logic [7:0]         in_source_sel,
  input  logic signed [31:0] in_immediate,
  input  logic               in_last_instruction,
  input  logic [5:0]         in_slot,
  input  logic [63:0]        in_context_req,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [63:0]        out_ret_value,
  output logic [1:0]         out_status
);

  localparam int PM_DEPTH = NUM_PROGRAMS * MAX_PROGRAM_LEN;
  localparam int PM_AW    = (PM_DEPTH > 1) ? $clog2(PM_DEPTH) : 1;
  localparam int PROG_W   = $clog2(NUM_PROGRAMS + 1);
  localparam int PSLOT_W  = (NUM_PROGRAMS > 1) ? $clog2(NUM_PROGRAMS) : 1;
  localparam int LEN_W    = $clog2(MAX_PROGRAM_LEN + 1);
  localparam int RIDX_W   = $clog2(NUM_REGS);
  localparam int CMP_W    = (PROG_W > 6) ? PROG_W : 6;

  vm_state_t state_r, state_nxt;

  logic [PROG_W-1:0] loaded_r, loaded_nxt;
  logic [LEN_W-1:0]  pos_r, pos_nxt;
  logic [PM_AW-1:0]  base_r, base_nxt;
  logic [LEN_W-1:0]  pc_r, pc_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic              iv_r, iv_nxt;
  logic              ev_r, ev_nxt;
  insn_t             e_insn_r, e_insn_nxt;
  logic              fwa_r, fwa_nxt;
  logic              fwb_r, fwb_nxt;
  logic              va_r, va_nxt;
  logic              vb_r, vb_nxt;
  logic [63:0]       wd_r, wd_nxt;
  logic [63:0]       res_r, res_nxt;
  logic [1:0]        stat_r, stat_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [63:0]       out_ret_r, out_ret_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic [NUM_REGS-1:0] rv_r, rv_nxt;

  insn_t             pm_mem [PM_DEPTH];
  logic              pm_we;
  logic [PM_AW-1:0]  pm_wa;
  insn_t             pm_wd;
  logic [PM_AW-1:0]  pm_ra;
  insn_t             pm_rd_r;

  logic [LEN_W-1:0]   pl_mem [NUM_PROGRAMS];
  logic               pl_we;
  logic [PSLOT_W-1:0] pl_wa;
  logic [LEN_W-1:0]   pl_wd;
  logic [PSLOT_W-1:0] pl_ra;
  logic [LEN_W-1:0]   pl_rd_r;

  logic [63:0]       rf_mem [NUM_REGS];
  logic              rf_we;
  logic [RIDX_W-1:0] rf_wa;
  logic [63:0]       rf_wd;
  logic [RIDX_W-1:0] rf_ra;
  logic [RIDX_W-1:0] rf_rb;
  logic [63:0]       rf_rda_r;
  logic [63:0]       rf_rdb_r;

  logic [RIDX_W-1:0] ridx_lut [16];

  for (genvar i = 0; i < 16; i++) begin : g_ridx
    assign ridx_lut[i] = RIDX_W'(i % NUM_REGS);
  end

  logic        accept;
  logic        stop;
  logic        fetch;
  logic [63:0] a_val;
  logic [63:0] b_val;
  logic [63:0] imm_ext;
  logic [63:0] operand;
  logic [PSLOT_W-1:0] slot_idx;
  logic [PSLOT_W-1:0] loaded_idx;

  assign in_stall      = (state_r != S_IDLE);
  assign accept        = in_valid && !in_stall;
  assign out_valid     = out_valid_r;
  assign out_ret_value = out_ret_r;
  assign out_status    = out_status_r;

  assign slot_idx   = PSLOT_W'(in_slot);
  assign loaded_idx = PSLOT_W'(loaded_r);
  assign a_val      = fwa_r ? wd_r : (va_r ? rf_rda_r : 64'd0);
  assign b_val      = fwb_r ? wd_r : (vb_r ? rf_rdb_r : 64'd0);
  assign imm_ext    = {{32{e_insn_r.imm[31]}}, e_insn_r.imm};
  assign operand    = (e_insn_r.src == SEL_IMM) ? imm_ext : b_val;
  assign stop       = ev_r && (e_insn_r.op == OP_RET);
  assign fetch      = (state_r == S_RUN) && !stop && (pc_r < len_r);

  always_comb begin
    state_nxt      = state_r;
    loaded_nxt     = loaded_r;
    pos_nxt        = pos_r;
    base_nxt       = base_r;
    pc_nxt         = pc_r;
    len_nxt        = len_r;
    iv_nxt         = 1'b0;
    ev_nxt         = 1'b0;
    e_insn_nxt     = pm_rd_r;
    res_nxt        = res_r;
    stat_nxt       = stat_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_ret_nxt    = out_ret_r;
    out_status_nxt = out_status_r;
    rv_nxt         = rv_r;

    pm_we = 1'b0;
    pm_wa = PM_AW'(PM_AW'(loaded_idx) * PM_AW'(MAX_PROGRAM_LEN)) + PM_AW'(pos_r);
    pm_wd = '{op: in_opcode, dst: in_dest_reg, src: in_source_sel,
              imm: $unsigned(in_immediate)};
    pm_ra = base_r + PM_AW'(pc_r);

    pl_we = 1'b0;
    pl_wa = loaded_idx;
    pl_wd = pos_r;
    pl_ra = slot_idx;

    rf_we = 1'b0;
    rf_wa = ridx_lut[e_insn_r.dst];
    rf_wd = 64'd0;
    rf_ra = (pm_rd_r.op == OP_RET) ? RIDX_W'(0) : ridx_lut[pm_rd_r.dst];
    rf_rb = ridx_lut[pm_rd_r.src[3:0]];

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (!in_kind) begin
            if (loaded_r < PROG_W'(NUM_PROGRAMS)) begin
              if (pos_r < LEN_W'(MAX_PROGRAM_LEN)) begin
                pm_we   = 1'b1;
                pos_nxt = pos_r + LEN_W'(1);
              end
              if (in_last_instruction) begin
                pl_we      = 1'b1;
                pl_wd      = pos_nxt;
                loaded_nxt = loaded_r + PROG_W'(1);
                pos_nxt    = '0;
              end
            end
          end else if (CMP_W'(in_slot) >= CMP_W'(loaded_r)) begin
            res_nxt   = 64'd0;
            stat_nxt  = STAT_BAD;
            state_nxt = S_DONE;
          end else begin
            base_nxt  = PM_AW'(PM_AW'(slot_idx) * PM_AW'(MAX_PROGRAM_LEN));
            pc_nxt    = '0;
            rf_we     = 1'b1;
            rf_wa     = '0;
            rf_wd     = in_context_req;
            rv_nxt    = '0;
            rv_nxt[0] = 1'b1;
            state_nxt = S_SETUP;
          end
        end
      end
      S_SETUP: begin
        len_nxt   = pl_rd_r;
        state_nxt = S_RUN;
      end
      S_RUN: begin
        if (fetch) begin
          pc_nxt = pc_r + LEN_W'(1);
          iv_nxt = 1'b1;
        end
        ev_nxt = iv_r && !stop;
        if (ev_r) begin
          unique case (e_insn_r.op)
            OP_ADD: begin
              rf_we = 1'b1;
              rf_wd = a_val + operand;
            end
            OP_SUB: begin
              rf_we = 1'b1;
              rf_wd = a_val - operand;
            end
            OP_LD: begin
              rf_we = 1'b1;
              rf_wd = imm_ext;
            end
            OP_RET: begin
              iv_nxt    = 1'b0;
              res_nxt   = a_val;
              stat_nxt  = STAT_RET;
              state_nxt = S_DONE;
            end
            default: begin
            end
          endcase
        end
        if (rf_we) begin
          rv_nxt[rf_wa] = 1'b1;
        end
        if (!stop && !fetch && !iv_r && !ev_r) begin
          res_nxt   = 64'd0;
          stat_nxt  = STAT_END;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_ret_nxt    = res_r;
          out_status_nxt = stat_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    fwa_nxt = rf_we && (rf_wa == rf_ra);
    fwb_nxt = rf_we && (rf_wa == rf_rb);
    va_nxt  = rv_r[rf_ra];
    vb_nxt  = rv_r[rf_rb];
    wd_nxt  = rf_wd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      loaded_r    <= '0;
      pos_r       <= '0;
      iv_r        <= 1'b0;
      ev_r        <= 1'b0;
      out_valid_r <= 1'b0;
      rv_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      loaded_r    <= loaded_nxt;
      pos_r       <= pos_nxt;
      iv_r        <= iv_nxt;
      ev_r        <= ev_nxt;
      out_valid_r <= out_valid_nxt;
      rv_r        <= rv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r       <= base_nxt;
    pc_r         <= pc_nxt;
    len_r        <= len_nxt;
    e_insn_r     <= e_insn_nxt;
    fwa_r        <= fwa_nxt;
    fwb_r        <= fwb_nxt;
    va_r         <= va_nxt;
    vb_r         <= vb_nxt;
    wd_r         <= wd_nxt;
    res_r        <= res_nxt;
    stat_r       <= stat_nxt;
    out_ret_r    <= out_ret_nxt;
    out_status_r <= out_status_nxt;
  end

  always_ff @(posedge clk) begin
    if (pm_we) begin
      pm_mem[pm_wa] <= pm_wd;
    end
    pm_rd_r <= pm_mem[pm_ra];
  end

  always_ff @(posedge clk) begin
    if (pl_we) begin
      pl_mem[pl_wa] <= pl_wd;
    end
    pl_rd_r <= pl_mem[pl_ra];
  end

  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf_mem[rf_wa] <= rf_wd;
    end
    rf_rda_r <= rf_mem[rf_ra];
    rf_rdb_r <= rf_mem[rf_rb];
  end

endmodule

@@ tb/tb_tiny_bytecode_vm_engine.sv @@
// Self-checking testbench for the bytecode VM engine: program loads, runs, store limits.
module tb_tiny_bytecode_vm_engine;
  import tbvm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PROG_SLOTS   = 64;
  localparam int PROG_DEPTH   = 256;
  localparam int REG_COUNT    = 16;
  localparam int ITEM_TARGET  = 1800;
  localparam int DRAIN_CYCLES = 300;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EXEC = 1'b1;

  typedef struct {
    logic        kind;
    logic [7:0]  op;
    logic [3:0]  dst;
    logic [7:0]  src;
    logic [31:0] imm;
    logic        last;
    logic [5:0]  slot;
    logic [63:0] ctx;
    logic        fixed;
    logic [63:0] fixed_ret;
    logic [1:0]  fixed_status;
  } vm_req_t;

  typedef struct packed {
    logic [63:0] ret;
    logic [1:0]  status;
  } vm_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_kind;
  logic [7:0]  in_opcode;
  logic [3:0]  in_dest_reg;
  logic [7:0]  in_source_sel;
  logic [31:0] in_immediate;
  logic        in_last_instruction;
  logic [5:0]  in_slot;
  logic [63:0] in_context_req;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] out_ret_value;
  logic [1:0]  out_status;

  insn_t      prog_mem [PROG_SLOTS][PROG_DEPTH];
  int         prog_len [PROG_SLOTS];
  int         slots_committed;
  int         fill_pos;
  vm_result_t pending_results [$];
  vm_req_t    directed_rows [$];

  bit idle_on = 1'b1;
  int errors;
  int n_items;
  int n_loads;
  int n_runs;
  int n_checked;
  int n_status [3];

  tiny_bytecode_vm_engine #(
    .NUM_PROGRAMS   (PROG_SLOTS),
    .MAX_PROGRAM_LEN(PROG_DEPTH),
    .NUM_REGS       (REG_COUNT)
  ) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_kind            (in_kind),
    .in_opcode          (in_opcode),
    .in_dest_reg        (in_dest_reg),
    .in_source_sel      (in_source_sel),
    .in_immediate       (in_immediate),
    .in_last_instruction(in_last_instruction),
    .in_slot            (in_slot),
    .in_context_req     (in_context_req),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_ret_value      (out_ret_value),
    .out_status         (out_status)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic vm_req_t load_row(input logic [7:0] op, input logic [3:0] dst,
                                       input logic [7:0] src, input logic [31:0] imm,
                                       input logic last);
    vm_req_t r;
    r.kind         = KIND_LOAD;
    r.op           = op;
    r.dst          = dst;
    r.src          = src;
    r.imm          = imm;
    r.last         = last;
    r.slot         = 6'($urandom);
    r.ctx          = {$urandom, $urandom};
    r.fixed        = 1'b0;
    r.fixed_ret    = '0;
    r.fixed_status = STAT_RET;
    return r;
  endfunction

  function automatic vm_req_t exec_row(input logic [5:0] slot, input logic [63:0] ctx,
                                       input logic fixed, input logic [63:0] fixed_ret,
                                       input logic [1:0] fixed_status);
    vm_req_t r;
    r.kind         = KIND_EXEC;
    r.op           = 8'($urandom);
    r.dst          = 4'($urandom);
    r.src          = 8'($urandom);
    r.imm          = $urandom;
    r.last         = 1'($urandom);
    r.slot         = slot;
    r.ctx          = ctx;
    r.fixed        = fixed;
    r.fixed_ret    = fixed_ret;
    r.fixed_status = fixed_status;
    return r;
  endfunction

  function automatic void store_instruction(input vm_req_t r);
    if (slots_committed >= PROG_SLOTS) return;
    if (fill_pos < PROG_DEPTH) begin
      prog_mem[slots_committed][fill_pos] = '{op: r.op, dst: r.dst, src: r.src, imm: r.imm};
      fill_pos++;
    end
    if (r.last) begin
      prog_len[slots_committed] = fill_pos;
      slots_committed++;
      fill_pos = 0;
    end
  endfunction

  function automatic vm_result_t run_program(input logic [5:0] slot, input logic [63:0] ctx);
    logic [63:0] regs [REG_COUNT];
    logic [63:0] operand;
    logic [63:0] imm_ext;
    insn_t       ins;
    vm_result_t  res;
    res.ret    = '0;
    res.status = STAT_BAD;
    if (int'(slot) >= slots_committed) return res;
    for (int i = 0; i < REG_COUNT; i++) regs[i] = '0;
    regs[0] = ctx;
    res.status = STAT_END;
    for (int pc = 0; pc < prog_len[slot]; pc++) begin
      ins     = prog_mem[slot][pc];
      imm_ext = {{32{ins.imm[31]}}, ins.imm};
      operand = (ins.src == SEL_IMM) ? imm_ext : regs[ins.src[3:0] % REG_COUNT];
      case (ins.op)
        OP_ADD: regs[ins.dst % REG_COUNT] = regs[ins.dst % REG_COUNT] + operand;
        OP_SUB: regs[ins.dst % REG_COUNT] = regs[ins.dst % REG_COUNT] - operand;
        OP_LD:  regs[ins.dst % REG_COUNT] = imm_ext;
        OP_RET: begin
          res.ret    = regs[0];
          res.status = STAT_RET;
          return res;
        end
        default: ;
      endcase
    end
    return res;
  endfunction

  task automatic send_req(input vm_req_t r);
    vm_result_t res;
    while (idle_on && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_kind             <= r.kind;
    in_opcode           <= r.op;
    in_dest_reg         <= r.dst;
    in_source_sel       <= r.src;
    in_immediate        <= r.imm;
    in_last_instruction <= r.last;
    in_slot             <= r.slot;
    in_context_req      <= r.ctx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (r.kind == KIND_LOAD) begin
      if (slots_committed < PROG_SLOTS) begin
        n_loads++;
        n_items++;
      end
      store_instruction(r);
    end else begin
      res = run_program(r.slot, r.ctx);
      if (r.fixed) begin
        res.ret    = r.fixed_ret;
        res.status = r.fixed_status;
      end
      pending_results.push_back(res);
      n_runs++;
      n_items++;
    end
  endtask

  task automatic send_program(input int len);
    logic [7:0]  op;
    logic [7:0]  src;
    logic [31:0] imm;
    int          pick;
    int          small_val;
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 99);
      if (i == len - 1 && $urandom_range(0, 99) < 80) op = OP_RET;
      else if (pick < 35) op = OP_ADD;
      else if (pick < 60) op = OP_SUB;
      else if (pick < 80) op = OP_LD;
      else if (pick < 88 && len <= 64) op = OP_RET;
      else op = 8'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 40) src = SEL_IMM;
      else if (pick < 85) src = 8'($urandom_range(0, 15));
      else src = 8'($urandom);
      if ($urandom_range(0, 1) == 0) begin
        imm = $urandom;
      end else begin
        small_val = $urandom_range(0, 15);
        imm       = 32'(small_val - 8);
      end
      send_req(load_row(op, 4'($urandom), src, imm, i == len - 1));
    end
  endtask

  always @(posedge clk) begin
    out_stall <= idle_on && ($urandom_range(0, 99) < 33);
  end

  always @(posedge clk) begin
    vm_result_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: ret_value %h status %0d",
                 $time, out_ret_value, out_status);
        errors++;
      end else begin
        exp_res = pending_results.pop_front();
        n_checked++;
        if (exp_res.status <= STAT_BAD) n_status[exp_res.status]++;
        if (out_ret_value !== exp_res.ret) begin
          $display("%0t ret_value mismatch: expected %h, got %h",
                   $time, exp_res.ret, out_ret_value);
          errors++;
        end
        if (out_status !== exp_res.status) begin
          $display("%0t status mismatch: expected %0d, got %0d",
                   $time, exp_res.status, out_status);
          errors++;
        end
      end
    end
  end

  initial begin
    #100_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int len;
    logic [5:0] slot;
    rst_n               <= 1'b0;
    in_valid            <= 1'b0;
    in_kind             <= KIND_LOAD;
    in_opcode           <= '0;
    in_dest_reg         <= '0;
    in_source_sel       <= '0;
    in_immediate        <= '0;
    in_last_instruction <= 1'b0;
    in_slot             <= '0;
    in_context_req      <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    directed_rows.push_back(exec_row(6'd0, 64'd0, 1'b1, 64'd0, STAT_BAD));
    directed_rows.push_back(exec_row(6'd63, '1, 1'b1, 64'd0, STAT_BAD));
    directed_rows.push_back(load_row(OP_LD, 4'd1, 8'd0, 32'h7FFF_FFFF, 1'b0));
    directed_rows.push_back(load_row(OP_ADD, 4'd0, 8'd1, 32'h0, 1'b0));
    directed_rows.push_back(load_row(OP_ADD, 4'd0, SEL_IMM, 32'hFFFF_FFFF, 1'b0));
    directed_rows.push_back(load_row(OP_SUB, 4'd0, SEL_IMM, 32'h8000_0000, 1'b0));
    directed_rows.push_back(load_row(8'h04, 4'd15, 8'hF1, 32'h1234_5678, 1'b0));
    directed_rows.push_back(load_row(8'h00, 4'd0, 8'd0, 32'h0, 1'b0));
    directed_rows.push_back(load_row(OP_RET, 4'd15, SEL_IMM, 32'h0, 1'b1));
    directed_rows.push_back(exec_row(6'd0, 64'd0, 1'b0, 64'd0, STAT_RET));
    directed_rows.push_back(exec_row(6'd0, '1, 1'b0, 64'd0, STAT_RET));
    directed_rows.push_back(load_row(OP_LD, 4'd15, SEL_IMM, 32'h8000_0000, 1'b0));
    directed_rows.push_back(load_row(OP_SUB, 4'd0, 8'hEF, 32'h0, 1'b0));
    directed_rows.push_back(load_row(8'hFE, 4'd3, 8'd2, 32'hFFFF_FFFF, 1'b1));
    directed_rows.push_back(exec_row(6'd1, 64'd5, 1'b1, 64'd0, STAT_END));
    directed_rows.push_back(load_row(OP_RET, 4'd0, 8'd0, 32'h0, 1'b1));
    directed_rows.push_back(exec_row(6'd2, '1, 1'b1, '1, STAT_RET));
    directed_rows.push_back(exec_row(6'd2, 64'd0, 1'b1, 64'd0, STAT_RET));
    directed_rows.push_back(exec_row(6'd3, {$urandom, $urandom}, 1'b1, 64'd0, STAT_BAD));
    directed_rows.push_back(exec_row(6'd1, '1, 1'b0, 64'd0, STAT_END));
    foreach (directed_rows[i]) send_req(directed_rows[i]);

    while (n_items < ITEM_TARGET) begin
      idle_on = !(n_items >= 700 && n_items < 1000);
      if (slots_committed < PROG_SLOTS && $urandom_range(0, 99) < 30) begin
        if (slots_committed == 10) len = PROG_DEPTH + 4;
        else if (slots_committed == 40) len = PROG_DEPTH;
        else if ($urandom_range(0, 99) < 80) len = $urandom_range(1, 10);
        else len = $urandom_range(11, 48);
        send_program(len);
      end else begin
        if (slots_committed == PROG_SLOTS && $urandom_range(0, 99) < 5) begin
          send_req(load_row(8'($urandom), 4'($urandom), 8'($urandom), $urandom,
                            1'($urandom)));
        end
        if (slots_committed > 0 && $urandom_range(0, 99) < 85)
          slot = 6'($urandom_range(0, slots_committed - 1));
        else
          slot = 6'($urandom);
        send_req(exec_row(slot, {$urandom, $urandom}, 1'b0, 64'd0, STAT_RET));
      end
    end
    idle_on = 1'b1;
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests: %0d instruction loads into %0d programs, %0d runs",
             n_items, n_loads, slots_committed, n_runs);
    $display("Checked %0d results: %0d returned, %0d ran off the end, %0d bad slot",
             n_checked, n_status[0], n_status[1], n_status[2]);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
